>>> rtl/dtc_pkg.sv
package dtc_pkg;

  localparam int MAX_COLS_DEF = 10;
  localparam int ROWS_W = 16;
  localparam int COLS_W = 4;
  localparam int CNT_W = 64;

  typedef struct packed {
    logic start;
    logic clr_step;
    logic row_begin;
    logic mask_rd;
    logic expand;
    logic swap;
    logic fin;
  } dtc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mask_last;
    logic cnt_nz;
    logic stack_empty;
  } dtc_sts_t;

endpackage

>>> rtl/dtc_ram.sv
module dtc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/dtc_datapath.sv
module dtc_datapath #(
  parameter int MAX_COLS = dtc_pkg::MAX_COLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [dtc_pkg::COLS_W-1:0] width,
  input  dtc_pkg::dtc_cmd_t         cmd,
  output dtc_pkg::dtc_sts_t         sts,
  output logic [dtc_pkg::CNT_W-1:0] result
);
  import dtc_pkg::*;

  localparam int DEPTH = 1 << MAX_COLS;
  localparam int AW = MAX_COLS;
  localparam int SD = MAX_COLS + 1;
  localparam int SPW = $clog2(SD + 1);
  localparam int CW = $clog2(MAX_COLS + 3);

  // Two banks; bank_r selects which one holds the current row.
  logic          bank_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] src_r;
  logic [CNT_W-1:0] cnt_r;
  logic [AW-1:0] stk_mask [SD];
  logic [CW-1:0] stk_col [SD];
  logic [SPW-1:0] sp_r;
  logic [AW:0]   masks;

  // Accumulation into next row: read, then write back via acc_pend_r and acc_addr_r.
  logic          acc_pend_r;
  logic [AW-1:0] acc_addr_r;

  logic [AW-1:0] ra0, ra1, wa0, wa1;
  logic          we0, we1;
  logic [CNT_W-1:0] wd0, wd1, rd0, rd1, rd_cur, rd_nxt;

  logic [CW-1:0] top_col;
  logic [AW-1:0] top_mask, bitm, bitm1;
  logic          leaf, busy_acc;

  assign masks = (AW+1)'(1) << width;
  assign rd_cur = bank_r ? rd1 : rd0;
  assign rd_nxt = bank_r ? rd0 : rd1;

  assign top_col = stk_col[sp_r == '0 ? '0 : sp_r - SPW'(1)];
  assign top_mask = stk_mask[sp_r == '0 ? '0 : sp_r - SPW'(1)];
  assign leaf = top_col >= CW'(width);
  assign bitm = AW'(1) << top_col;
  assign bitm1 = AW'(1) << (top_col + CW'(1));
  assign busy_acc = acc_pend_r;

  dtc_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_ram0 (
    .clk(clk), .we(we0), .waddr(wa0), .wdata(wd0), .raddr(ra0), .rdata(rd0));
  dtc_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_ram1 (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(ra1), .rdata(rd1));

  logic [AW-1:0] rd_addr_cur, rd_addr_nxt, wr_addr;
  logic          wr_cur, wr_nxt;
  logic [CNT_W-1:0] wr_data;
  logic          do_leaf;

  assign do_leaf = cmd.expand && sp_r != '0 && leaf && !busy_acc;

  always_comb begin
    rd_addr_cur = src_r;
    rd_addr_nxt = top_mask;
    wr_cur = 1'b0;
    wr_nxt = 1'b0;
    wr_addr = clr_addr_r;
    wr_data = '0;
    if (cmd.clr_step) begin
      wr_cur = 1'b1;
      wr_nxt = 1'b1;
      wr_data = (clr_addr_r == '0) ? CNT_W'(1) : '0;
    end else if (cmd.row_begin) begin
      wr_nxt = 1'b1;
    end else if (acc_pend_r) begin
      wr_nxt = 1'b1;
      wr_addr = acc_addr_r;
      wr_data = rd_nxt + cnt_r;
    end
    if (cmd.fin) begin
      rd_addr_cur = '0;
    end
  end

  // Clear of the current bank uses the same address sweep; entry 0 gets 1.
  assign we0 = bank_r ? wr_nxt : wr_cur;
  assign we1 = bank_r ? wr_cur : wr_nxt;
  assign wa0 = wr_addr;
  assign wa1 = wr_addr;
  assign wd0 = (bank_r ? wr_nxt : wr_cur) && !bank_r && cmd.clr_step ? wr_data :
               (bank_r && cmd.clr_step) ? '0 : wr_data;
  assign wd1 = (!bank_r && cmd.clr_step) ? '0 : wr_data;
  assign ra0 = bank_r ? rd_addr_nxt : rd_addr_cur;
  assign ra1 = bank_r ? rd_addr_cur : rd_addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      clr_addr_r <= '0;
      src_r <= '0;
      sp_r <= '0;
      acc_pend_r <= 1'b0;
    end else begin
      acc_pend_r <= do_leaf;
      if (cmd.start) begin
        bank_r <= 1'b0;
        clr_addr_r <= '0;
      end
      if (cmd.clr_step || cmd.row_begin) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.row_begin && clr_addr_r == AW'(DEPTH - 1)) begin
        src_r <= '0;
      end
      if (cmd.mask_rd) begin
        cnt_r <= rd_cur;
        if (rd_cur != '0) begin
          stk_col[0] <= '0;
          stk_mask[0] <= '0;
          sp_r <= SPW'(1);
        end else begin
          src_r <= src_r + AW'(1);
        end
      end
      if (cmd.expand && sp_r != '0 && !busy_acc) begin
        if (leaf) begin
          acc_addr_r <= top_mask;
          sp_r <= sp_r - SPW'(1);
          if (sp_r == SPW'(1)) begin
            src_r <= src_r + AW'(1);
          end
        end else if ((src_r & bitm) != '0) begin
          stk_col[sp_r - SPW'(1)] <= top_col + CW'(1);
        end else begin
          stk_col[sp_r - SPW'(1)] <= top_col + CW'(1);
          stk_mask[sp_r - SPW'(1)] <= top_mask | bitm;
          if (top_col + CW'(1) < CW'(width) && (src_r & bitm1) == '0) begin
            stk_col[sp_r] <= top_col + CW'(2);
            stk_mask[sp_r] <= top_mask;
            sp_r <= sp_r + SPW'(1);
          end
        end
      end
      if (cmd.swap) begin
        bank_r <= ~bank_r;
        clr_addr_r <= '0;
      end
    end
  end

  assign sts.clr_done = clr_addr_r == AW'(DEPTH - 1);
  assign sts.mask_last = ({1'b0, src_r} + (AW+1)'(1)) >= masks || src_r == AW'(DEPTH-1);
  assign sts.cnt_nz = sp_r != '0;
  assign sts.stack_empty = sp_r == '0 && !acc_pend_r;
  assign result = rd_cur;

endmodule

>>> rtl/dtc_ctrl.sv
module dtc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [dtc_pkg::ROWS_W-1:0]  rows,
  input  logic                        too_wide,
  input  dtc_pkg::dtc_sts_t           sts,
  output dtc_pkg::dtc_cmd_t           cmd,
  output logic                        res_valid,
  output logic                        res_zero,
  input  logic                        res_taken
);
  import dtc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CLR  = 9'b000000010,
    S_ROW  = 9'b000000100,
    S_RD   = 9'b000001000,
    S_CAP  = 9'b000010000,
    S_EXP  = 9'b000100000,
    S_SWAP = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [ROWS_W-1:0] rows_r, row_r;
  logic zero_r;
  logic last_r;

  assign in_tready = state_r == S_IDLE;
  assign res_valid = state_r == S_OUT;
  assign res_zero = zero_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = too_wide ? S_FIN : S_CLR;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = (rows_r == '0) ? S_FIN : S_ROW;
      end
      S_ROW: begin
        cmd.row_begin = 1'b1;
        if (sts.clr_done) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CAP;
      end
      S_CAP: begin
        cmd.mask_rd = 1'b1;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        cmd.expand = 1'b1;
        if (sts.stack_empty) begin
          state_nxt = last_r ? S_SWAP : S_RD;
        end
      end
      S_SWAP: begin
        cmd.swap = 1'b1;
        state_nxt = (row_r + ROWS_W'(1) == rows_r) ? S_FIN : S_ROW;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.fin = 1'b1;
        if (res_taken) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rows_r <= '0;
      row_r <= '0;
      zero_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_tvalid) begin
        rows_r <= rows;
        row_r <= '0;
        zero_r <= too_wide;
      end
      if (state_r == S_RD) last_r <= sts.mask_last;
      if (state_r == S_SWAP) row_r <= row_r + ROWS_W'(1);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && !res_taken |=> state_r == S_OUT)
    else $error("result dropped before handshake");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWAP |-> sts.stack_empty)
    else $error("row swap with transitions pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_valid)
    else $error("accept while result pending");

endmodule

>>> rtl/domino_tiling_counter.sv
// Channel | Ports             | Payload
// in      | in_tvalid/tready  | tdata[15:0] rows, tdata[19:16] cols
// out     | out_tvalid/tready | tdata[63:0] tiling_count
// One request at a time. A job first clears both count memories in one sweep,
// then per row clears the next-row memory, reads, captures and expands each
// profile mask stack step by stack step (each completed transition adds a
// next-row read then write), and ends the row with a swap. The result is
// valid after the last row's swap and then S_FIN; after acceptance and S_FIN
// when the width is too large; or after the clear and S_FIN when rows is zero.
// Reset is synchronous, active low. A stalled result holds until taken.
module domino_tiling_counter #(
  parameter int MAX_COLS = dtc_pkg::MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // rows[15:0], cols[19:16], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // tiling_count[63:0]
);
  import dtc_pkg::*;

  dtc_cmd_t cmd;
  dtc_sts_t sts;
  logic [COLS_W-1:0] width_r;
  logic [CNT_W-1:0] result;
  logic zero;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) width_r <= in_tdata[19:16];
  end

  dtc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .rows(in_tdata[15:0]),
    .too_wide(32'(in_tdata[19:16]) > MAX_COLS),
    .sts(sts), .cmd(cmd), .res_valid(out_tvalid), .res_zero(zero),
    .res_taken(out_tready));

  dtc_datapath #(.MAX_COLS(MAX_COLS)) u_dp (
    .clk(clk), .rst_n(rst_n), .width(width_r), .cmd(cmd), .sts(sts),
    .result(result));

  assign out_tdata = zero ? '0 : result;

endmodule
